>>> hdl/serpentine_raster_scan_controller_macros.svh
// assertion macros shared by the scan controller checker
`ifndef SERPENTINE_RASTER_SCAN_CONTROLLER_MACROS_SVH
`define SERPENTINE_RASTER_SCAN_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SRSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scan controller check failed");

// next-cycle implication, disabled while reset is asserted
`define SRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scan controller check failed");

`endif

>>> hdl/srsc_pkg.sv
// shared types and constants of the serpentine raster scan controller
`timescale 1ns / 1ps

package srsc_pkg;

	localparam int unsigned POS_W   = 16;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned Q_DEPTH = 2;

	localparam logic [POS_W-1:0] MID_SCALE = 16'h8000;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_BEGIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_END    = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_BEGIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_Y_END    = 3'd4;
	localparam logic [IDX_W-1:0] REG_STEP     = 3'd5;
	localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd6;
	localparam logic [IDX_W-1:0] REG_CRASH    = 3'd7;

	localparam logic [POS_W-1:0] CRASH_RESET = 16'h8000;

	typedef enum logic [KIND_W-1:0] {
		KIND_IDLE     = 3'd0,
		KIND_STARTED  = 3'd1,
		KIND_ZSTEP    = 3'd2,
		KIND_MEASURED = 3'd3,
		KIND_BACKWARD = 3'd4
	} kind_t;

	typedef struct packed {
		logic             cc_mode;
		logic [POS_W-1:0] x_begin;
		logic [POS_W-1:0] x_end;
		logic [POS_W-1:0] y_begin;
		logic [POS_W-1:0] y_end;
		logic [POS_W-1:0] step_size;
		logic [POS_W-1:0] setpoint;
		logic [POS_W-1:0] crash_limit;
	} cfg_t;

	// one classified transaction waiting for the back end
	typedef struct packed {
		logic             opcode;
		logic [POS_W-1:0] sample;
		logic [POS_W-1:0] z_start;
		logic [POS_W-1:0] mid_dist;
		logic             below_set;
		logic             above_crash;
	} entry_t;

endpackage

>>> hdl/srsc_front.sv
// front end: classifies incoming transactions ahead of the sequencer
`timescale 1ns / 1ps

module srsc_front (
	input  logic                       in_valid,
	input  logic                       q_full,
	input  logic                       opcode,
	input  logic [srsc_pkg::POS_W-1:0] sample,
	input  logic [srsc_pkg::POS_W-1:0] z_start,
	input  srsc_pkg::cfg_t             cfg,
	output logic                       push,
	output srsc_pkg::entry_t           entry
);

	logic [srsc_pkg::POS_W-1:0] mid_dist;

	// distance from mid-scale, at most half scale
	always_comb begin
		if (sample[srsc_pkg::POS_W-1]) begin
			mid_dist = sample - srsc_pkg::MID_SCALE;
		end else begin
			mid_dist = srsc_pkg::MID_SCALE - sample;
		end
	end

	assign push              = in_valid & ~q_full;
	assign entry.opcode      = opcode;
	assign entry.sample      = sample;
	assign entry.z_start     = z_start;
	assign entry.mid_dist    = mid_dist;
	assign entry.below_set   = mid_dist < cfg.setpoint;
	assign entry.above_crash = mid_dist > cfg.crash_limit;

endmodule

>>> hdl/srsc_queue.sv
// short queue between front end and sequencer
`timescale 1ns / 1ps

module srsc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  srsc_pkg::entry_t wr_entry,
	input  logic             pop,
	output srsc_pkg::entry_t rd_entry,
	output logic             full,
	output logic             not_empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	srsc_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

>>> hdl/srsc_back.sv
// back end: scan position state, z feedback and result register
`timescale 1ns / 1ps

module srsc_back #(
	parameter int unsigned Z_STEP        = 1,
	parameter int unsigned RETRACT_STEP  = 0,
	parameter int unsigned START_BACKOFF = 1000
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  srsc_pkg::cfg_t             cfg,
	input  srsc_pkg::entry_t           entry,
	input  logic                       q_not_empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output srsc_pkg::kind_t            kind,
	output logic [srsc_pkg::POS_W-1:0] x_pos,
	output logic [srsc_pkg::POS_W-1:0] y_pos,
	output logic [srsc_pkg::POS_W-1:0] z_pos,
	output logic [srsc_pkg::POS_W-1:0] pixel_value,
	output logic                       crash_retreat,
	output logic                       z_fault,
	output logic                       scan_done
);

	localparam int unsigned W = srsc_pkg::POS_W;
	localparam logic [W-1:0] ZSTEP_C   = W'(Z_STEP);
	localparam logic [W-1:0] RETRACT_C = W'(RETRACT_STEP);
	localparam logic [W-1:0] BACKOFF_C = W'(START_BACKOFF);

	logic [W-1:0] x_q, y_q, z_q;
	logic         fwd_q, active_q;
	logic [W-1:0] x_d, y_d, z_d;
	logic         fwd_d, active_d;

	logic         out_valid_q;
	srsc_pkg::kind_t kind_q, kind_d;
	logic [W-1:0] rx_q, ry_q, z_out_q, pix_q;
	logic [W-1:0] rx_d, ry_d, pix_d;
	logic         crash_q, fault_q, done_q;
	logic         crash_d, fault_d, done_d, adv;

	logic [W:0]   z_up, x_fwd, x_lim, y_next;

	assign pop   = q_not_empty & (~out_valid_q | ~out_stall);
	assign z_up  = {1'b0, z_q} + {1'b0, ZSTEP_C};
	assign x_fwd = {1'b0, x_q} + {1'b0, cfg.step_size};
	// stepping back would cross x_begin or go below zero
	assign x_lim  = {1'b0, cfg.step_size} + {1'b0, cfg.x_begin};
	assign y_next = {1'b0, y_q} + {1'b0, cfg.step_size};

	always_comb begin
		x_d      = x_q;
		y_d      = y_q;
		z_d      = z_q;
		fwd_d    = fwd_q;
		active_d = active_q;
		kind_d   = srsc_pkg::KIND_IDLE;
		rx_d     = x_q;
		ry_d     = y_q;
		pix_d    = '0;
		crash_d  = 1'b0;
		fault_d  = 1'b0;
		done_d   = 1'b0;
		adv      = 1'b0;
		if (entry.opcode == srsc_pkg::OP_START) begin
			x_d      = cfg.x_begin;
			y_d      = cfg.y_begin;
			z_d      = entry.z_start;
			if (cfg.cc_mode) begin
				if (entry.z_start < BACKOFF_C) begin
					z_d     = '0;
					fault_d = 1'b1;
				end else begin
					z_d = entry.z_start - BACKOFF_C;
				end
			end
			fwd_d    = 1'b1;
			active_d = 1'b1;
			kind_d   = srsc_pkg::KIND_STARTED;
			rx_d     = cfg.x_begin;
			ry_d     = cfg.y_begin;
		end else if (active_q) begin
			adv = 1'b1;
			if (!fwd_q) begin
				kind_d = srsc_pkg::KIND_BACKWARD;
			end else if (!cfg.cc_mode) begin
				kind_d  = srsc_pkg::KIND_MEASURED;
				pix_d   = entry.sample;
				crash_d = entry.above_crash;
			end else if (entry.below_set) begin
				if (z_up[W]) begin
					z_d     = '1;
					fault_d = 1'b1;
					kind_d  = srsc_pkg::KIND_MEASURED;
				end else begin
					z_d    = z_up[W-1:0];
					kind_d = srsc_pkg::KIND_ZSTEP;
					adv    = 1'b0;
				end
			end else begin
				kind_d = srsc_pkg::KIND_MEASURED;
				if (z_q < RETRACT_C) begin
					z_d     = '0;
					fault_d = 1'b1;
				end else begin
					z_d     = z_q - RETRACT_C;
					pix_d   = entry.mid_dist;
					crash_d = entry.above_crash;
				end
			end
		end
		if (adv) begin
			if (fwd_q) begin
				if (x_fwd > {1'b0, cfg.x_end}) begin
					fwd_d = 1'b0;
				end else begin
					x_d = x_fwd[W-1:0];
				end
			end else if ({1'b0, x_q} < x_lim) begin
				fwd_d = 1'b1;
				if (y_next > {1'b0, cfg.y_end}) begin
					active_d = 1'b0;
					done_d   = 1'b1;
				end else begin
					y_d = y_next[W-1:0];
				end
			end else begin
				x_d = x_q - cfg.step_size;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			fwd_q       <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				x_q      <= x_d;
				y_q      <= y_d;
				z_q      <= z_d;
				fwd_q    <= fwd_d;
				active_q <= active_d;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= q_not_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= kind_d;
			rx_q    <= rx_d;
			ry_q    <= ry_d;
			z_out_q <= z_d;
			pix_q   <= pix_d;
			crash_q <= crash_d;
			fault_q <= fault_d;
			done_q  <= done_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign x_pos         = rx_q;
	assign y_pos         = ry_q;
	assign z_pos         = z_out_q;
	assign pixel_value   = pix_q;
	assign crash_retreat = crash_q;
	assign z_fault       = fault_q;
	assign scan_done     = done_q;

endmodule

>>> hdl/serpentine_raster_scan_controller.sv
// top level of the serpentine raster scan controller
`timescale 1ns / 1ps

// serpentine raster scan controller for a scanning probe
// input channel: in_valid / in_stall with opcode, sample and z_start; a transaction
//   moves at a rising edge with in_valid high and in_stall low
// opcode start loads x,y from their begin registers and z from z_start (less the
//   start backoff in constant-current mode); opcode sample handles one pixel
// output channel: out_valid / out_stall, one result transaction per input transaction,
//   in order; the result payload holds while out_stall is high
// configuration: cfg_valid / cfg_ready write port, cfg_index selects the register,
//   cfg_ready is always high; write only while no transaction is in flight
// an accepted transaction is written into the queue, and the result register loads it
//   from the queue head once that register is free; out_valid then rises
// throughput: one transaction per cycle while out_stall is low; the sequencer does a
//   handful of 17-bit adds and compares on the registered scan state each cycle
// a two-entry queue parts front end and sequencer; in_stall rises only when it is full,
//   which happens once out_stall has held back the result register
// reset: asynchronous, scan idle, positions zero, crash limit at mid-scale distance,
//   other configuration registers zero; no clearing pass is needed
module serpentine_raster_scan_controller #(
	parameter int unsigned Z_STEP        = 1,
	parameter int unsigned RETRACT_STEP  = 0,
	parameter int unsigned START_BACKOFF = 1000
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input transactions
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [srsc_pkg::POS_W-1:0] sample,
	input  logic [srsc_pkg::POS_W-1:0] z_start,
	// result transactions
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [srsc_pkg::KIND_W-1:0] kind,
	output logic [srsc_pkg::POS_W-1:0] x_pos,
	output logic [srsc_pkg::POS_W-1:0] y_pos,
	output logic [srsc_pkg::POS_W-1:0] z_pos,
	output logic [srsc_pkg::POS_W-1:0] pixel_value,
	output logic                       crash_retreat,
	output logic                       z_fault,
	output logic                       scan_done,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [srsc_pkg::IDX_W-1:0] cfg_index,
	input  logic [srsc_pkg::POS_W-1:0] cfg_data
);

	srsc_pkg::cfg_t   cfg_q;
	srsc_pkg::entry_t push_entry;
	srsc_pkg::entry_t head_entry;
	srsc_pkg::kind_t  kind_w;
	logic             push, pop, q_full, q_not_empty;

	// register file, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{cc_mode: 1'b0, x_begin: '0, x_end: '0, y_begin: '0, y_end: '0,
				step_size: '0, setpoint: '0, crash_limit: srsc_pkg::CRASH_RESET};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srsc_pkg::REG_MODE:     cfg_q.cc_mode     <= cfg_data[0];
				srsc_pkg::REG_X_BEGIN:  cfg_q.x_begin     <= cfg_data;
				srsc_pkg::REG_X_END:    cfg_q.x_end       <= cfg_data;
				srsc_pkg::REG_Y_BEGIN:  cfg_q.y_begin     <= cfg_data;
				srsc_pkg::REG_Y_END:    cfg_q.y_end       <= cfg_data;
				srsc_pkg::REG_STEP:     cfg_q.step_size   <= cfg_data;
				srsc_pkg::REG_SETPOINT: cfg_q.setpoint    <= cfg_data;
				srsc_pkg::REG_CRASH:    cfg_q.crash_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end: mid-scale distance and threshold compares
	srsc_front u_front (
		.in_valid (in_valid),
		.q_full   (q_full),
		.opcode   (opcode),
		.sample   (sample),
		.z_start  (z_start),
		.cfg      (cfg_q),
		.push     (push),
		.entry    (push_entry)
	);

	assign in_stall = q_full;

	// decoupling queue
	srsc_queue #(
		.DEPTH (srsc_pkg::Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (push_entry),
		.pop       (pop),
		.rd_entry  (head_entry),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// sequencer and result register
	srsc_back #(
		.Z_STEP        (Z_STEP),
		.RETRACT_STEP  (RETRACT_STEP),
		.START_BACKOFF (START_BACKOFF)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.entry         (head_entry),
		.q_not_empty   (q_not_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind_w),
		.x_pos         (x_pos),
		.y_pos         (y_pos),
		.z_pos         (z_pos),
		.pixel_value   (pixel_value),
		.crash_retreat (crash_retreat),
		.z_fault       (z_fault),
		.scan_done     (scan_done)
	);

	assign kind = kind_w;

endmodule

>>> hdl/srsc_checker.sv
// port-level checker for the scan controller, bound to the top level
`timescale 1ns / 1ps
`include "serpentine_raster_scan_controller_macros.svh"

module srsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [srsc_pkg::KIND_W-1:0] kind,
	input logic [srsc_pkg::POS_W-1:0]  x_pos,
	input logic [srsc_pkg::POS_W-1:0]  z_pos,
	input logic [srsc_pkg::POS_W-1:0]  pixel_value,
	input logic                        crash_retreat,
	input logic                        z_fault,
	input logic                        scan_done
);

	// a stalled result holds
	`SRSC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(x_pos) && $stable(z_pos))

	// only a measured pixel carries a value or a crash flag
	`SRSC_ASSERT_IMPLY(a_pix_measured, clk, arst_n, out_valid && kind != srsc_pkg::KIND_MEASURED, pixel_value == '0 && !crash_retreat)

	// the scan finishes only on a backward pixel
	`SRSC_ASSERT_IMPLY(a_done_back, clk, arst_n, out_valid && scan_done, kind == srsc_pkg::KIND_BACKWARD)

	// a z fault comes from start backoff or feedback, never with a crash flag
	`SRSC_ASSERT_IMPLY(a_fault_kind, clk, arst_n, out_valid && z_fault, (kind == srsc_pkg::KIND_STARTED || kind == srsc_pkg::KIND_MEASURED) && pixel_value == '0 && !crash_retreat)

endmodule

bind serpentine_raster_scan_controller srsc_checker u_srsc_checker (.*);

>>> sim/srsc_tb_pkg.sv
// scan position predictor and result scoreboard for the scan controller testbench
`timescale 1ns / 1ps

package srsc_tb_pkg;

	import srsc_pkg::*;

	localparam int unsigned SCAN_Z_STEP        = 1;
	localparam int unsigned SCAN_RETRACT_STEP  = 0;
	localparam int unsigned SCAN_START_BACKOFF = 1000;
	localparam logic [31:0] FULL_SCALE         = 32'hFFFF;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] y_pos;
		logic [POS_W-1:0] z_pos;
		logic [POS_W-1:0] pixel_value;
		logic             crash_retreat;
		logic             z_fault;
		logic             scan_done;
	} scan_result_t;

	class raster_scoreboard;

		cfg_t             regs;
		logic [POS_W-1:0] x_at;
		logic [POS_W-1:0] y_at;
		logic [POS_W-1:0] z_at;
		bit               forward;
		bit               scanning;
		scan_result_t     pending_pixels[$];
		int unsigned      errors;
		int unsigned      results;
		int unsigned      live_items;
		int unsigned      faults;
		int unsigned      crashes;
		int unsigned      finishes;
		int unsigned      kind_tally[8];

		function new();
			regs = '0;
			regs.crash_limit = CRASH_RESET;
			x_at = '0;
			y_at = '0;
			z_at = '0;
			forward = 0;
			scanning = 0;
			errors = 0;
			results = 0;
			live_items = 0;
			faults = 0;
			crashes = 0;
			finishes = 0;
			foreach (kind_tally[i]) kind_tally[i] = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [POS_W-1:0] data);
			case (idx)
			REG_MODE:     regs.cc_mode = data[0];
			REG_X_BEGIN:  regs.x_begin = data;
			REG_X_END:    regs.x_end = data;
			REG_Y_BEGIN:  regs.y_begin = data;
			REG_Y_END:    regs.y_end = data;
			REG_STEP:     regs.step_size = data;
			REG_SETPOINT: regs.setpoint = data;
			REG_CRASH:    regs.crash_limit = data;
			default: ;
			endcase
		endfunction

		function int unsigned outstanding();
			return pending_pixels.size();
		endfunction

		// serpentine move to the next pixel, next row after a backward pass
		function void next_pixel(output bit done);
			logic [31:0] nx;
			logic [31:0] ny;
			done = 0;
			if (forward) begin
				nx = x_at + regs.step_size;
				if (nx > regs.x_end)
					forward = 0;
				else
					x_at = nx[POS_W-1:0];
			end else if (x_at < regs.step_size || x_at - regs.step_size < regs.x_begin) begin
				ny = y_at + regs.step_size;
				forward = 1;
				if (ny > regs.y_end) begin
					scanning = 0;
					done = 1;
				end else begin
					y_at = ny[POS_W-1:0];
				end
			end else begin
				x_at = x_at - regs.step_size;
			end
		endfunction

		function void take_command(logic op, logic [POS_W-1:0] smp, logic [POS_W-1:0] zs);
			scan_result_t r;
			logic [31:0]  mid_dist;
			logic [31:0]  nz;
			bit           move_on;
			bit           done;
			r = '0;
			r.kind = KIND_IDLE;
			r.x_pos = x_at;
			r.y_pos = y_at;
			move_on = 1;
			done = 0;
			mid_dist = (smp >= MID_SCALE) ? smp - MID_SCALE : MID_SCALE - smp;
			if (op == OP_START) begin
				x_at = regs.x_begin;
				y_at = regs.y_begin;
				z_at = zs;
				if (regs.cc_mode) begin
					if (zs < SCAN_START_BACKOFF) begin
						z_at = '0;
						r.z_fault = 1;
					end else begin
						nz = zs - SCAN_START_BACKOFF;
						z_at = nz[POS_W-1:0];
					end
				end
				forward = 1;
				scanning = 1;
				r.kind = KIND_STARTED;
				r.x_pos = x_at;
				r.y_pos = y_at;
			end else if (scanning) begin
				if (!forward) begin
					r.kind = KIND_BACKWARD;
				end else if (!regs.cc_mode) begin
					r.kind = KIND_MEASURED;
					r.pixel_value = smp;
					r.crash_retreat = mid_dist > regs.crash_limit;
				end else if (mid_dist < regs.setpoint) begin
					nz = z_at + SCAN_Z_STEP;
					if (nz > FULL_SCALE) begin
						z_at = FULL_SCALE[POS_W-1:0];
						r.z_fault = 1;
						r.kind = KIND_MEASURED;
					end else begin
						z_at = nz[POS_W-1:0];
						r.kind = KIND_ZSTEP;
						move_on = 0;
					end
				end else begin
					r.kind = KIND_MEASURED;
					if (z_at < SCAN_RETRACT_STEP) begin
						z_at = '0;
						r.z_fault = 1;
					end else begin
						nz = z_at - SCAN_RETRACT_STEP;
						z_at = nz[POS_W-1:0];
						r.pixel_value = mid_dist[POS_W-1:0];
						r.crash_retreat = mid_dist > regs.crash_limit;
					end
				end
				if (move_on) next_pixel(done);
				r.scan_done = done;
			end
			r.z_pos = z_at;
			kind_tally[r.kind]++;
			if (r.kind != KIND_IDLE) live_items++;
			if (r.z_fault) faults++;
			if (r.crash_retreat) crashes++;
			if (r.scan_done) finishes++;
			pending_pixels.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
			errors++;
			$display("mismatch in %s on result %0d: got %0d, expected %0d",
				what, results, got_v, want_v);
		endtask

		task match_result(scan_result_t got);
			scan_result_t want;
			results++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("result with none outstanding", got.kind, 0);
				return;
			end
			want = pending_pixels.pop_front();
			if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
			if (got.x_pos !== want.x_pos) report_mismatch("x_pos", got.x_pos, want.x_pos);
			if (got.y_pos !== want.y_pos) report_mismatch("y_pos", got.y_pos, want.y_pos);
			if (got.z_pos !== want.z_pos) report_mismatch("z_pos", got.z_pos, want.z_pos);
			if (got.pixel_value !== want.pixel_value)
				report_mismatch("pixel_value", got.pixel_value, want.pixel_value);
			if (got.crash_retreat !== want.crash_retreat)
				report_mismatch("crash_retreat", got.crash_retreat, want.crash_retreat);
			if (got.z_fault !== want.z_fault)
				report_mismatch("z_fault", got.z_fault, want.z_fault);
			if (got.scan_done !== want.scan_done)
				report_mismatch("scan_done", got.scan_done, want.scan_done);
		endtask

	endclass

endpackage

>>> sim/serpentine_raster_scan_controller_tb.sv
// self-checking testbench of the serpentine raster scan controller
`timescale 1ns / 1ps

module serpentine_raster_scan_controller_tb;

	import srsc_pkg::*;
	import srsc_tb_pkg::*;

	localparam int unsigned LATENCY      = 2;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned TARGET_ITEMS = 500;
	localparam int unsigned PRESS_HOLD   = 60;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                opcode;
	logic [POS_W-1:0]    sample;
	logic [POS_W-1:0]    z_start;
	logic                out_valid;
	logic                out_stall;
	logic [KIND_W-1:0]   kind;
	logic [POS_W-1:0]    x_pos;
	logic [POS_W-1:0]    y_pos;
	logic [POS_W-1:0]    z_pos;
	logic [POS_W-1:0]    pixel_value;
	logic                crash_retreat;
	logic                z_fault;
	logic                scan_done;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [POS_W-1:0]    cfg_data;

	raster_scoreboard    sb;
	int unsigned         quiet_cycles;
	int unsigned         phases;
	bit                  press_req;
	bit                  press_done;

	serpentine_raster_scan_controller #(
		.Z_STEP        (SCAN_Z_STEP),
		.RETRACT_STEP  (SCAN_RETRACT_STEP),
		.START_BACKOFF (SCAN_START_BACKOFF)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.sample        (sample),
		.z_start       (z_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.x_pos         (x_pos),
		.y_pos         (y_pos),
		.z_pos         (z_pos),
		.pixel_value   (pixel_value),
		.crash_retreat (crash_retreat),
		.z_fault       (z_fault),
		.scan_done     (scan_done),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: any cycle that moves a transaction on any channel resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					quiet_cycles + 1, sb.outstanding());
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// result side: sample at the rising edge, choose the next stall at the falling edge
	// segments of no stall, light random, periodic and heavy random stalling; one long
	// hold-off on request so that the block backs up into its input
	initial begin : result_sink
		int unsigned  style;
		int unsigned  seg;
		int unsigned  cyc;
		int unsigned  hold_left;
		scan_result_t got;
		out_stall = 1'b0;
		press_done = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			style = $urandom_range(0, 3);
			seg = $urandom_range(20, 80);
			for (cyc = 0; cyc < seg; cyc++) begin
				@(posedge clk);
				if (out_valid && !out_stall) begin
					got.kind = kind_t'(kind);
					got.x_pos = x_pos;
					got.y_pos = y_pos;
					got.z_pos = z_pos;
					got.pixel_value = pixel_value;
					got.crash_retreat = crash_retreat;
					got.z_fault = z_fault;
					got.scan_done = scan_done;
					sb.match_result(got);
				end
				@(negedge clk);
				if (hold_left > 0) begin
					out_stall = 1'b1;
					hold_left--;
				end else if (press_req && !press_done) begin
					// long hold-off, counted here while the sender keeps offering
					press_done = 1;
					hold_left = PRESS_HOLD - 1;
					out_stall = 1'b1;
				end else begin
					case (style)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 2) == 0);
					2: out_stall = (cyc % 4 == 3);
					default: out_stall = ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	// one input transaction; payload holds until it is taken
	task automatic send_item(logic op, logic [POS_W-1:0] smp, logic [POS_W-1:0] zs);
		@(negedge clk);
		in_valid = 1'b1;
		opcode = op;
		sample = smp;
		z_start = zs;
		do @(posedge clk); while (in_stall);
		sb.take_command(op, smp, zs);
	endtask

	// gap on the input side, payload scrambled while idle
	task automatic pause_input(int unsigned n);
		if (n == 0) return;
		@(negedge clk);
		in_valid = 1'b0;
		opcode = $urandom_range(0, 1);
		sample = $urandom;
		z_start = $urandom;
		repeat (n - 1) @(negedge clk);
	endtask

	// wait until every result is back, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_register(logic [IDX_W-1:0] idx, logic [POS_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// full register set, written only once the block has gone quiet
	task automatic program_scan(logic mode, logic [POS_W-1:0] xb, logic [POS_W-1:0] xe,
			logic [POS_W-1:0] yb, logic [POS_W-1:0] ye, logic [POS_W-1:0] st,
			logic [POS_W-1:0] sp, logic [POS_W-1:0] cl);
		settle();
		// upper bits of the mode word are don't-care, so scramble them
		write_register(REG_MODE, {15'($urandom), mode});
		write_register(REG_X_BEGIN, xb);
		write_register(REG_X_END, xe);
		write_register(REG_Y_BEGIN, yb);
		write_register(REG_Y_END, ye);
		write_register(REG_STEP, st);
		write_register(REG_SETPOINT, sp);
		write_register(REG_CRASH, cl);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// converter readings biased towards mid-scale, the rails and the setpoint edge
	function automatic logic [POS_W-1:0] pick_sample();
		logic [31:0] sp;
		logic [31:0] v;
		sp = sb.regs.setpoint;
		case ($urandom_range(0, 9))
		0: v = 32'h0;
		1: v = 32'hFFFF;
		2: v = MID_SCALE;
		3: v = MID_SCALE + $urandom_range(0, 3);
		4: v = (sp >= 32768) ? 32'hFFFF : MID_SCALE + sp;
		5: v = (sp >= 32768) ? 32'h0 : MID_SCALE - sp;
		6: v = (sp >= 32768) ? 32'h1 : MID_SCALE - sp + 1;
		default: v = $urandom;
		endcase
		return v[POS_W-1:0];
	endfunction

	// z hand-over values around the start backoff and the rails
	function automatic logic [POS_W-1:0] pick_z();
		logic [31:0] v;
		case ($urandom_range(0, 5))
		0: v = 32'h0;
		1: v = SCAN_START_BACKOFF - 1;
		2: v = SCAN_START_BACKOFF;
		3: v = 32'hFFFF;
		default: v = $urandom;
		endcase
		return v[POS_W-1:0];
	endfunction

	// mostly short scans that finish, with full-range and degenerate set-ups mixed in
	task automatic random_config();
		logic [31:0] xb;
		logic [31:0] xe;
		logic [31:0] yb;
		logic [31:0] ye;
		logic [31:0] st;
		logic [31:0] sp;
		logic [31:0] cl;
		logic        m;
		m = $urandom_range(0, 1);
		case ($urandom_range(0, 7))
		0: begin
			xb = 0; xe = 32'hFFFF; yb = 0; ye = 32'hFFFF; st = 32'hFFFF;
		end
		1: begin
			xb = 0; xe = 0; yb = 0; ye = 0; st = 0;
		end
		2: begin
			xb = $urandom_range(0, 65535);
			xe = $urandom_range(0, 65535);
			yb = $urandom_range(0, 65535);
			ye = $urandom_range(0, 65535);
			st = $urandom_range(0, 65535);
		end
		default: begin
			st = $urandom_range(1, 3000);
			xb = $urandom_range(0, 65535);
			xe = xb + st * $urandom_range(0, 3) + $urandom_range(0, st - 1);
			if (xe > 32'hFFFF) xe = 32'hFFFF;
			yb = $urandom_range(0, 65535);
			ye = yb + st * $urandom_range(0, 2);
			if (ye > 32'hFFFF) ye = 32'hFFFF;
		end
		endcase
		case ($urandom_range(0, 5))
		0: sp = 0;
		1: sp = 32768;
		default: sp = $urandom_range(0, 32768);
		endcase
		case ($urandom_range(0, 5))
		0: cl = 0;
		1: cl = 32768;
		default: cl = $urandom_range(0, 32768);
		endcase
		program_scan(m, xb[POS_W-1:0], xe[POS_W-1:0], yb[POS_W-1:0], ye[POS_W-1:0],
			st[POS_W-1:0], sp[POS_W-1:0], cl[POS_W-1:0]);
	endtask

	task automatic directed_part();
		// sample with no scan running is ignored
		send_item(OP_SAMPLE, 16'h1234, 16'h0000);
		// constant height at the top corner: crash on a rail sample, finish on the
		// first backward pixel as y runs past its end, then ignored again
		program_scan(1'b0, 16'd65000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		send_item(OP_START, 16'h0000, 16'hFFFF);
		send_item(OP_SAMPLE, 16'h0000, 16'h0000);
		send_item(OP_SAMPLE, 16'hFFFF, 16'h0000);
		send_item(OP_SAMPLE, MID_SCALE, 16'h0000);
		// constant current on a zero step: backoff below zero, z steps, restarts
		program_scan(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd32768);
		send_item(OP_START, 16'h0000, 16'(SCAN_START_BACKOFF - 1));
		send_item(OP_SAMPLE, MID_SCALE, 16'h0000);
		send_item(OP_SAMPLE, 16'h0000, 16'h0000);
		send_item(OP_SAMPLE, 16'h0001, 16'h0000);
		send_item(OP_START, 16'hFFFF, 16'(SCAN_START_BACKOFF));
		send_item(OP_START, 16'h0000, 16'hFFFF);
		send_item(OP_SAMPLE, 16'h8001, 16'h0000);
		// z parked at full scale in constant height, then a z step in constant current
		// saturates; the scan still advances past each faulted pixel
		program_scan(1'b0, 16'd5, 16'd6, 16'd0, 16'd1, 16'd1, 16'd0, 16'd32768);
		send_item(OP_START, 16'h0000, 16'hFFFF);
		program_scan(1'b1, 16'd5, 16'd6, 16'd0, 16'd1, 16'd1, 16'd1, 16'd32768);
		repeat (4) send_item(OP_SAMPLE, MID_SCALE, 16'h0000);
		// step larger than the position: row change from the begin edge
		program_scan(1'b0, 16'd0, 16'd10, 16'd3, 16'd20, 16'd7, 16'd0, 16'd100);
		send_item(OP_START, 16'h0000, 16'd500);
		send_item(OP_SAMPLE, 16'hFFFF, 16'h0000);
		send_item(OP_SAMPLE, 16'h7FFF, 16'h0000);
		send_item(OP_SAMPLE, 16'h0001, 16'h0000);
		send_item(OP_SAMPLE, MID_SCALE, 16'h0000);
		send_item(OP_SAMPLE, 16'hC000, 16'h0000);
		send_item(OP_SAMPLE, 16'h3FFF, 16'h0000);
	endtask

	// one register setting followed by a run of scan transactions
	task automatic random_phase();
		int unsigned n;
		int unsigned style;
		int unsigned burst_left;
		int unsigned gap;
		logic        op;
		random_config();
		phases++;
		style = $urandom_range(0, 2);
		n = $urandom_range(15, 60);
		// second phase: back-to-back offers against the long receiver hold-off
		if (phases == 2) begin
			press_req = 1;
			style = 0;
			n = 40;
		end
		burst_left = 0;
		for (int k = 0; k < n; k++) begin
			if (k == 0)
				op = ($urandom_range(0, 9) != 0) ? OP_START : OP_SAMPLE;
			else if (!sb.scanning && $urandom_range(0, 1) == 1)
				op = OP_START;
			else
				op = ($urandom_range(0, 99) < 4) ? OP_START : OP_SAMPLE;
			if (style != 0 && burst_left == 0) begin
				gap = (style == 1) ? $urandom_range(1, 5) : $urandom_range(0, 8);
				pause_input(gap);
				burst_left = (style == 1) ? $urandom_range(1, 16) : 1;
			end
			if (burst_left > 0) burst_left--;
			send_item(op, pick_sample(), pick_z());
		end
	endtask

	// main sequence: reset, directed corners, random phases, drain, verdict
	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_START;
		sample = '0;
		z_start = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		press_req = 0;
		quiet_cycles = 0;
		phases = 0;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_part();
		while (sb.live_items < TARGET_ITEMS)
			random_phase();

		// drain the last results and give the pipeline time to show any extra ones
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4 * LATENCY + 8) @(posedge clk);

		$display("covered %0d results over %0d random settings: %0d starts, %0d z steps, %0d measured, %0d backward, %0d ignored",
			sb.results, phases, sb.kind_tally[KIND_STARTED], sb.kind_tally[KIND_ZSTEP],
			sb.kind_tally[KIND_MEASURED], sb.kind_tally[KIND_BACKWARD],
			sb.kind_tally[KIND_IDLE]);
		$display("z faults %0d, crash retreats %0d, scans finished %0d, mismatches %0d",
			sb.faults, sb.crashes, sb.finishes, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
